### hdl/fmidd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FM discriminator package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package fmidd_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 14;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int STAGE_LIMIT         = 24;
	localparam int STAGE_W             = $clog2(STAGE_LIMIT);

	localparam int SAMPLE_W   = 16;
	localparam int PRODUCT_W  = 32;
	localparam int PRESCALE   = 24;
	localparam int CORDIC_W   = PRODUCT_W + PRESCALE + 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] SAMPLE_CENTER   = 8'd127;
	localparam logic [7:0] DECIMATION_RST  = 8'd10;
	localparam logic [31:0] PI_INTERNAL    = 32'h8000_0000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// new decimated sample and the one before it
	typedef struct packed {
		sample_t zi;
		sample_t zq;
		sample_t pi;
		sample_t pq;
	} pair_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_ADD,
		BK_PREP,
		BK_ROT,
		BK_SCALE,
		BK_EMIT
	} back_state_t;

	// round(atan(2^-s) * 2^31 / pi)
	function automatic logic [31:0] arc_angle(input logic [STAGE_W-1:0] idx);
		logic [31:0] a;
		case (idx)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

### hdl/fm_iq_decimate_discriminator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FM I/Q decimating discriminator
// Integrate-and-dump decimation of centred I/Q bytes followed by a CORDIC
// polar discriminator on the conjugate product of successive sums.
//
//   channel   handshake                       payload
//   sample    sample_valid / sample_stall     i_sample, q_sample
//   result    result_valid / result_stall     freq_deviation
//   config    decimation_factor_we            decimation_factor
//
// A non-completing request is taken every cycle while the queue has room.
// A completing request passes through the angle unit as 4 multiplier steps
// on one shared 16x16 multiplier, the sum, the CORDIC setup, one CORDIC
// stage a cycle, scaling and the result; special angles skip the rotations
// and scaling. Two sums queue ahead of it. Reset clears sums, count,
// previous sample and the queue; factor returns to 10. A held result stalls the angle unit, then the queue, then input.
// ----------------------------------------------------------------------------
module fm_iq_decimate_discriminator_unit
	import fmidd_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        decimation_factor_we,
	input  wire logic [7:0]  decimation_factor,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire logic [7:0]  i_sample,
	input  wire logic [7:0]  q_sample,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic signed [15:0] freq_deviation
);

	logic  q_push, q_pop, q_full, q_empty;
	pair_t q_wdata, q_rdata;

	fmidd_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.decimation_factor_we (decimation_factor_we),
		.decimation_factor    (decimation_factor),
		.sample_valid         (sample_valid),
		.sample_stall         (sample_stall),
		.i_sample             (i_sample),
		.q_sample             (q_sample),
		.q_full               (q_full),
		.q_push               (q_push),
		.q_wdata              (q_wdata)
	);

	fmidd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	fmidd_back #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STAGES   (CORDIC_STAGES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_rdata        (q_rdata),
		.q_pop          (q_pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.freq_deviation (freq_deviation)
	);

endmodule
`default_nettype wire

### hdl/fmidd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FM discriminator front end
// Centres raw I/Q bytes, integrates over the decimation count and pushes each
// completed sum with the previous one into the queue.
// ----------------------------------------------------------------------------
module fmidd_front
	import fmidd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       decimation_factor_we,
	input  wire logic [7:0] decimation_factor,
	input  wire logic       sample_valid,
	output logic            sample_stall,
	input  wire logic [7:0] i_sample,
	input  wire logic [7:0] q_sample,
	input  wire logic       q_full,
	output logic            q_push,
	output pair_t           q_wdata
);

	logic [7:0]  factor_q;
	logic [7:0]  count_q;
	sample_t     sum_i_q, sum_q_q, prev_i_q, prev_q_q;
	logic        accept;
	logic signed [8:0] ci, cq;
	sample_t     sum_i_n, sum_q_n;
	logic [7:0]  count_n, factor;
	logic        dump;

	assign sample_stall = q_full;
	assign accept = sample_valid && !sample_stall;

	assign ci = $signed({1'b0, i_sample}) - $signed({1'b0, SAMPLE_CENTER});
	assign cq = $signed({1'b0, q_sample}) - $signed({1'b0, SAMPLE_CENTER});
	assign sum_i_n = sum_i_q + SAMPLE_W'(ci);
	assign sum_q_n = sum_q_q + SAMPLE_W'(cq);
	assign count_n = count_q + 8'd1;
	assign factor  = (factor_q == 8'd0) ? 8'd1 : factor_q;
	assign dump    = (count_n == 8'd0) || (count_n >= factor);

	assign q_push  = accept && dump;
	assign q_wdata = '{zi: sum_i_n, zq: sum_q_n, pi: prev_i_q, pq: prev_q_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= DECIMATION_RST;
			count_q  <= '0;
			sum_i_q  <= '0;
			sum_q_q  <= '0;
			prev_i_q <= '0;
			prev_q_q <= '0;
		end else begin
			if (decimation_factor_we) begin
				factor_q <= decimation_factor;
			end
			if (accept) begin
				if (dump) begin
					prev_i_q <= sum_i_n;
					prev_q_q <= sum_q_n;
					sum_i_q  <= '0;
					sum_q_q  <= '0;
					count_q  <= '0;
				end else begin
					sum_i_q <= sum_i_n;
					sum_q_q <= sum_q_n;
					count_q <= count_n;
				end
			end
		end
	end

endmodule
`default_nettype wire

### hdl/fmidd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FM discriminator queue
// Short FIFO of sample pairs between the front end and the angle unit.
// ----------------------------------------------------------------------------
module fmidd_queue
	import fmidd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire pair_t wdata,
	input  wire logic  pop,
	output pair_t      rdata,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pair_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/fmidd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FM discriminator angle unit
// Conjugate product on one shared multiplier, iterative CORDIC vectoring,
// scaling and the result register.
// ----------------------------------------------------------------------------
module fmidd_back
	import fmidd_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire pair_t       q_rdata,
	output logic             q_pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic signed [15:0] freq_deviation
);

	localparam int NUM_STAGES = (CORDIC_STAGES < STAGE_LIMIT) ? CORDIC_STAGES : STAGE_LIMIT;
	localparam int SHIFT      = 31 - ANGLE_FRAC_BITS;
	localparam logic signed [32:0] ROUND_ADJ = 33'((64'd1 << SHIFT) - 64'd1);
	localparam logic signed [15:0] PI_OUT    = 16'(32'd1 << ANGLE_FRAC_BITS);
	localparam logic signed [15:0] HALF_PI   = 16'(32'd1 << (ANGLE_FRAC_BITS - 1));

	typedef logic signed [CORDIC_W-1:0] wide_t;

	back_state_t state_q, state_n;
	pair_t       pair_q;
	logic [1:0]  mul_cnt_q;
	logic signed [PRODUCT_W-1:0] prod_q [4];
	logic signed [PRODUCT_W-1:0] cr_q, cj_q;
	wide_t       x_q, y_q;
	logic [31:0] z_q;
	logic [STAGE_W-1:0] stage_q;
	logic signed [15:0] res_q;
	logic        out_valid_q;
	logic signed [15:0] out_q;

	sample_t     mul_a, mul_b;
	logic signed [PRODUCT_W-1:0] prod;
	wide_t       cr_w, cj_w, dx, dy;
	logic        y_pos, slot_free;
	logic [31:0] arc;
	logic signed [32:0] zs, zs_adj, zs_shr;

	assign slot_free      = !out_valid_q || !result_stall;
	assign result_valid   = out_valid_q;
	assign freq_deviation = out_q;

	always_comb begin
		case (mul_cnt_q)
			2'd0:    begin mul_a = pair_q.zi; mul_b = pair_q.pi; end
			2'd1:    begin mul_a = pair_q.zq; mul_b = pair_q.pq; end
			2'd2:    begin mul_a = pair_q.zq; mul_b = pair_q.pi; end
			2'd3:    begin mul_a = pair_q.zi; mul_b = pair_q.pq; end
			default: begin mul_a = pair_q.zi; mul_b = pair_q.pi; end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign cr_w  = CORDIC_W'(cr_q) <<< PRESCALE;
	assign cj_w  = CORDIC_W'(cj_q) <<< PRESCALE;
	assign dx    = y_q >>> stage_q;
	assign dy    = x_q >>> stage_q;
	assign y_pos = !y_q[CORDIC_W-1] && (y_q != '0);
	assign arc   = arc_angle(stage_q);

	assign zs     = (z_q == PI_INTERNAL) ? 33'sh0_8000_0000 : $signed({z_q[31], z_q});
	assign zs_adj = zs[32] ? zs + ROUND_ADJ : zs;
	assign zs_shr = zs_adj >>> SHIFT;

	always_comb begin
		state_n = state_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_n = BK_MUL;
				end
			end
			BK_MUL: begin
				if (mul_cnt_q == 2'd3) begin
					state_n = BK_ADD;
				end
			end
			BK_ADD: state_n = BK_PREP;
			BK_PREP: begin
				if (cj_q == '0 || cr_q == '0) begin
					state_n = BK_EMIT;
				end else begin
					state_n = BK_ROT;
				end
			end
			BK_ROT: begin
				if (stage_q == STAGE_W'(NUM_STAGES - 1)) begin
					state_n = BK_SCALE;
				end
			end
			BK_SCALE: state_n = BK_EMIT;
			BK_EMIT: begin
				if (slot_free) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				pair_q    <= q_rdata;
				mul_cnt_q <= '0;
			end
			BK_MUL: begin
				prod_q[mul_cnt_q] <= prod;
				mul_cnt_q         <= mul_cnt_q + 2'd1;
			end
			BK_ADD: begin
				cr_q <= prod_q[0] + prod_q[1];
				cj_q <= prod_q[2] - prod_q[3];
			end
			BK_PREP: begin
				stage_q <= '0;
				if (cj_q == '0) begin
					res_q <= cr_q[PRODUCT_W-1] ? PI_OUT : '0;
				end else if (cr_q == '0) begin
					res_q <= cj_q[PRODUCT_W-1] ? -HALF_PI : HALF_PI;
				end
				if (cr_q[PRODUCT_W-1]) begin
					x_q <= -cr_w;
					y_q <= -cj_w;
					z_q <= PI_INTERNAL;
				end else begin
					x_q <= cr_w;
					y_q <= cj_w;
					z_q <= '0;
				end
			end
			BK_ROT: begin
				stage_q <= stage_q + STAGE_W'(1);
				if (y_pos) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + arc;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - arc;
				end
			end
			BK_SCALE: res_q <= zs_shr[15:0];
			BK_EMIT: begin
				if (slot_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM I/Q decimating discriminator testbench
// Sends I/Q byte requests through a table of directed cases, then through
// random or full-scale phases at several decimation factors. Each phase
// starts only once the block has gone idle. Every deviation result is
// checked against its table value or a CORDIC angle predictor that runs
// on the same integrate-and-dump sums. Both sides idle and stall in random
// bursts; one phase holds the result side off to back-pressure sample input.
// ----------------------------------------------------------------------------
module testbench
	import fmidd_pkg::*;
();

	localparam int FRAC_BITS      = ANGLE_FRAC_BITS_DEF;
	localparam int NUM_STAGES     = CORDIC_STAGES_DEF;
	localparam int SETTLE_CYCLES  = 48;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic [31:0] ATAN_STEP [STAGE_LIMIT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic              cfg_en;
		logic [7:0]        cfg_val;
		logic [7:0]        iv;
		logic [7:0]        qv;
		logic              dev_en;
		logic signed [15:0] dev;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               decimation_factor_we;
	logic [7:0]         decimation_factor;
	logic               sample_valid;
	logic               sample_stall;
	logic [7:0]         i_sample;
	logic [7:0]         q_sample;
	logic               result_valid;
	logic               result_stall;
	logic signed [15:0] freq_deviation;

	// predictor state
	logic [7:0]         factor_now;
	logic signed [15:0] acc_i, acc_q, last_i, last_q;
	logic [7:0]         acc_count;

	logic signed [15:0] freq_dev_q [$];
	stim_row_t          stim_rows [$];
	logic signed [15:0] want_dev;
	logic [7:0]         prev_iv, prev_qv;

	int  err_count;
	int  sent_count;
	int  got_count;
	int  idle_run;
	bit  quiet;
	bit  tx_calm;
	bit  rx_calm;
	bit  hold_req;

	fm_iq_decimate_discriminator_unit #(
		.ANGLE_FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES(NUM_STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.decimation_factor_we(decimation_factor_we),
		.decimation_factor(decimation_factor),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.i_sample(i_sample),
		.q_sample(q_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.freq_deviation(freq_deviation)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// angle of cr + j*cj, 2^FRAC_BITS = pi, truncated toward zero
	function automatic logic signed [15:0] conj_angle(input longint cr, input longint cj);
		longint      x, y, dx, dy, za;
		logic [31:0] z;
		int          stages;
		if (cj == 0)
			return (cr < 0) ? 16'(longint'(1) << FRAC_BITS) : 16'sd0;
		if (cr == 0)
			return (cj > 0) ? 16'(longint'(1) << (FRAC_BITS - 1))
				: 16'(-(longint'(1) << (FRAC_BITS - 1)));
		x = cr * (longint'(1) << PRESCALE);
		y = cj * (longint'(1) << PRESCALE);
		z = 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = PI_INTERNAL;
		end
		stages = (NUM_STAGES < STAGE_LIMIT) ? NUM_STAGES : STAGE_LIMIT;
		for (int s = 0; s < stages; s++) begin
			dx = y >>> s;
			dy = x >>> s;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_STEP[s];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_STEP[s];
			end
		end
		if (z == PI_INTERNAL)
			za = longint'(1) << 31;
		else
			za = longint'(signed'(z));
		return 16'(za / (longint'(1) << (31 - FRAC_BITS)));
	endfunction

	// integrate one centred pair; returns 1 when a decimated sample completes
	function automatic bit integrate_pair(input logic [7:0] iv, input logic [7:0] qv,
		output logic signed [15:0] dev);
		int         ci, cq;
		logic [7:0] eff;
		longint     cr, cj;
		ci = int'(iv) - int'(SAMPLE_CENTER);
		cq = int'(qv) - int'(SAMPLE_CENTER);
		acc_i = acc_i + 16'(ci);
		acc_q = acc_q + 16'(cq);
		acc_count = acc_count + 8'd1;
		eff = (factor_now == 8'd0) ? 8'd1 : factor_now;
		dev = 16'sd0;
		if (acc_count != 8'd0 && acc_count < eff)
			return 1'b0;
		cr = longint'(acc_i) * longint'(last_i) + longint'(acc_q) * longint'(last_q);
		cj = longint'(acc_q) * longint'(last_i) - longint'(acc_i) * longint'(last_q);
		dev = conj_angle(cr, cj);
		last_i = acc_i;
		last_q = acc_q;
		acc_i = 16'sd0;
		acc_q = 16'sd0;
		acc_count = 8'd0;
		return 1'b1;
	endfunction

	function automatic void add_row(input logic cfg_en, input logic [7:0] cfg_val,
		input logic [7:0] iv, input logic [7:0] qv, input logic dev_en,
		input logic signed [15:0] dev);
		stim_row_t r;
		r.cfg_en  = cfg_en;
		r.cfg_val = cfg_val;
		r.iv      = iv;
		r.qv      = qv;
		r.dev_en  = dev_en;
		r.dev     = dev;
		stim_rows.push_back(r);
	endfunction

	// entered and left just after a falling edge
	task automatic push_pair(input logic [7:0] iv, input logic [7:0] qv,
		input logic fixed_en, input logic signed [15:0] fixed_dev);
		logic signed [15:0] dev;
		bit                 done;
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
		if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		sample_valid <= 1'b1;
		i_sample     <= iv;
		q_sample     <= qv;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
		done = integrate_pair(iv, qv, dev);
		if (done)
			freq_dev_q.push_back(fixed_en ? fixed_dev : dev);
		else if (fixed_en) begin
			$display("%0t ns: expected deviation %0d, but the request completes no sum",
				$time, fixed_dev);
			err_count++;
		end
	endtask

	task automatic set_decimation(input logic [7:0] v);
		sample_valid <= 1'b0;
		while (freq_dev_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		decimation_factor_we <= 1'b1;
		decimation_factor    <= v;
		@(negedge clk);
		decimation_factor_we <= 1'b0;
		factor_now = v;
	endtask

	task automatic draw_pair(output logic [7:0] iv, output logic [7:0] qv);
		int r;
		r = $urandom_range(0, 19);
		if (r < 9) begin
			iv = 8'($urandom_range(0, 255));
			qv = 8'($urandom_range(0, 255));
		end else if (r < 13) begin
			iv = 8'(123 + $urandom_range(0, 8));
			qv = 8'(123 + $urandom_range(0, 8));
		end else if (r < 17) begin
			case ($urandom_range(0, 6))
				0: iv = 8'd0;
				1: iv = 8'd1;
				2: iv = 8'd126;
				3: iv = 8'd127;
				4: iv = 8'd128;
				5: iv = 8'd254;
				default: iv = 8'd255;
			endcase
			case ($urandom_range(0, 6))
				0: qv = 8'd0;
				1: qv = 8'd1;
				2: qv = 8'd126;
				3: qv = 8'd127;
				4: qv = 8'd128;
				5: qv = 8'd254;
				default: qv = 8'd255;
			endcase
		end else begin
			// repeated pair: at factor one, parallel samples, zero imaginary part
			iv = prev_iv;
			qv = prev_qv;
		end
		prev_iv = iv;
		prev_qv = qv;
	endtask

	task automatic run_phase(input logic [7:0] factor, input int n, input bit hold,
		input bit full_scale);
		logic [7:0] iv, qv;
		set_decimation(factor);
		if (hold)
			hold_req = 1'b1;
		for (int k = 0; k < n; k++) begin
			if (full_scale) begin
				iv = 8'd255;
				qv = 8'd0;
			end else
				draw_pair(iv, qv);
			push_pair(iv, qv, 1'b0, 16'sd0);
		end
	endtask

	// result side: random stall bursts, and one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			got_count++;
			if (freq_dev_q.size() == 0) begin
				$display("%0t ns: freq_deviation %0d with none expected", $time, freq_deviation);
				err_count++;
			end else begin
				want_dev = freq_dev_q.pop_front();
				if (freq_deviation !== want_dev) begin
					$display("%0t ns: freq_deviation expected %0d, got %0d",
						$time, want_dev, freq_deviation);
					err_count++;
				end
			end
		end
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		decimation_factor_we = 1'b0;
		decimation_factor    = 8'd0;
		sample_valid         = 1'b0;
		i_sample             = 8'd0;
		q_sample             = 8'd0;
		factor_now           = DECIMATION_RST;
		acc_i                = 16'sd0;
		acc_q                = 16'sd0;
		acc_count            = 8'd0;
		last_i               = 16'sd0;
		last_q               = 16'sd0;
		prev_iv              = 8'd127;
		prev_qv              = 8'd127;
		err_count            = 0;
		sent_count           = 0;
		got_count            = 0;
		idle_run             = 0;
		quiet                = 1'b0;
		tx_calm              = 1'b0;
		rx_calm              = 1'b0;
		hold_req             = 1'b0;

		// reset factor of ten; first completed sum has no previous sample
		add_row(0, 8'd0, 8'd0, 8'd255, 0, 16'sd0);
		add_row(0, 8'd0, 8'd255, 8'd0, 0, 16'sd0);
		add_row(0, 8'd0, 8'd0, 8'd0, 0, 16'sd0);
		add_row(0, 8'd0, 8'd255, 8'd255, 0, 16'sd0);
		add_row(0, 8'd0, 8'd127, 8'd127, 0, 16'sd0);
		add_row(0, 8'd0, 8'd128, 8'd126, 0, 16'sd0);
		add_row(0, 8'd0, 8'd1, 8'd254, 0, 16'sd0);
		add_row(0, 8'd0, 8'd170, 8'd85, 0, 16'sd0);
		add_row(0, 8'd0, 8'd85, 8'd170, 0, 16'sd0);
		add_row(0, 8'd0, 8'd127, 8'd127, 1, 16'sd0);
		// factor one: real axis, pi, +/- pi/2, zero sample
		add_row(1, 8'd1, 8'd128, 8'd127, 0, 16'sd0);
		add_row(0, 8'd0, 8'd128, 8'd127, 1, 16'sd0);
		add_row(0, 8'd0, 8'd126, 8'd127, 1, 16'sd16384);
		add_row(0, 8'd0, 8'd127, 8'd128, 1, -16'sd8192);
		add_row(0, 8'd0, 8'd128, 8'd127, 1, -16'sd8192);
		add_row(0, 8'd0, 8'd127, 8'd128, 1, 16'sd8192);
		add_row(0, 8'd0, 8'd127, 8'd127, 1, 16'sd0);
		add_row(0, 8'd0, 8'd255, 8'd255, 1, 16'sd0);
		// factor zero acts as one: opposite full-scale samples give pi
		add_row(1, 8'd0, 8'd0, 8'd0, 1, 16'sd16384);
		add_row(0, 8'd0, 8'd0, 8'd255, 0, 16'sd0);
		add_row(0, 8'd0, 8'd255, 8'd0, 0, 16'sd0);
		// factor lowered below the running count
		add_row(1, 8'd10, 8'd200, 8'd50, 0, 16'sd0);
		add_row(0, 8'd0, 8'd10, 8'd240, 0, 16'sd0);
		add_row(0, 8'd0, 8'd250, 8'd3, 0, 16'sd0);
		add_row(0, 8'd0, 8'd64, 8'd192, 0, 16'sd0);
		add_row(1, 8'd3, 8'd131, 8'd99, 0, 16'sd0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[k]) begin
			if (stim_rows[k].cfg_en)
				set_decimation(stim_rows[k].cfg_val);
			push_pair(stim_rows[k].iv, stim_rows[k].qv, stim_rows[k].dev_en,
				stim_rows[k].dev);
		end

		run_phase(8'd1, 150, 1'b1, 1'b0);
		run_phase(8'd2, 80, 1'b0, 1'b0);
		run_phase(8'd7, 63, 1'b0, 1'b0);
		run_phase(8'd255, 255, 1'b0, 1'b1);
		run_phase(8'd0, 50, 1'b0, 1'b0);
		run_phase(8'd3, 99, 1'b0, 1'b0);
		quiet = 1'b1;
		run_phase(8'd1, 90, 1'b0, 1'b0);

		sample_valid <= 1'b0;
		while (freq_dev_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d I/Q requests, checked %0d deviation results", sent_count, got_count);
		$display("over factors 10, 1, 0, 2, 3, 7 and 255, with a %0d-cycle result hold-off",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### fm_iq_decimate_discriminator_unit.f
hdl/fmidd_pkg.sv
hdl/fmidd_front.sv
hdl/fmidd_queue.sv
hdl/fmidd_back.sv
hdl/fm_iq_decimate_discriminator_unit.sv
tb/testbench.sv
